@@ sv/rsi_pkg.sv @@
package rsi_pkg;

	localparam int FRAC = 16;
	localparam int W = 32;
	localparam int RW = 31;
	localparam int IDW = 16;
	localparam int MDW = 16;
	localparam logic [MDW-1:0] MIN_DIST_RST = 16'd7;

	// Width of a Q product once the fraction bits have been dropped.
	localparam int PROD_W = 2 * W - FRAC;
	localparam int SUM_W = PROD_W + 2;

	localparam int RAD_W = 64;
	localparam int SQ_STAGES = RAD_W / 2;
	localparam int SQ_REM_W = SQ_STAGES + 4;
	localparam logic signed [63:0] DET_LIM = 64'sh7FFF_FFFF_FFFF_FFFF >>> FRAC;

	localparam int DIFF_W = W + 1;
	localparam int DVD_W = DIFF_W + FRAC;
	localparam int DIV_STAGES = DVD_W;
	localparam int DIV_REM_W = RW + 1;

	localparam int FRONT_STAGES = 5;
	localparam int POST_STAGES = 4;
	localparam int LATENCY = FRONT_STAGES + SQ_STAGES + POST_STAGES + DIV_STAGES + 1;

	typedef logic signed [W-1:0] fx_t;

	typedef struct packed {
		fx_t b;
		fx_t [2:0] org;
		fx_t [2:0] dir;
		fx_t [2:0] cen;
		logic [RW-1:0] r;
		logic [IDW-1:0] id;
	} sq_side_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_STAGES-1:0] root;
	} sq_step_t;

	typedef struct packed {
		logic [DIV_REM_W-1:0] rem;
		logic q;
	} div_step_t;

	typedef struct packed {
		logic hit;
		logic [RW-1:0] len;
		fx_t [2:0] pos;
		logic [2:0] sgn;
		logic rz;
		logic [IDW-1:0] id;
	} nrm_side_t;

	function automatic logic signed [63:0] sext(input fx_t v);
		return {{(64-W){v[W-1]}}, v};
	endfunction

	function automatic fx_t sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[W-1:0];
	endfunction

	// One digit of the square root: two radicand bits in, one root bit out.
	function automatic sq_step_t sq_step(input logic [SQ_REM_W-1:0] rem,
			input logic [SQ_STAGES-1:0] root, input logic [1:0] bits);
		logic [SQ_REM_W-1:0] rm;
		logic [SQ_REM_W-1:0] trial;
		sq_step_t o;
		rm = {rem[SQ_REM_W-3:0], bits};
		trial = {{(SQ_REM_W-SQ_STAGES-2){1'b0}}, root, 2'b01};
		if (rm >= trial) begin
			o.rem = rm - trial;
			o.root = {root[SQ_STAGES-2:0], 1'b1};
		end else begin
			o.rem = rm;
			o.root = {root[SQ_STAGES-2:0], 1'b0};
		end
		return o;
	endfunction

	// One bit of restoring division.
	function automatic div_step_t div_step(input logic [DIV_REM_W-1:0] rem, input logic nb,
			input logic [RW-1:0] dvs);
		logic [DIV_REM_W-1:0] rm;
		logic [DIV_REM_W-1:0] ext;
		div_step_t o;
		rm = {rem[DIV_REM_W-2:0], nb};
		ext = {1'b0, dvs};
		if (rm >= ext) begin
			o.rem = rm - ext;
			o.q = 1'b1;
		end else begin
			o.rem = rm;
			o.q = 1'b0;
		end
		return o;
	endfunction

endpackage

@@ sv/ray_sphere_intersect.sv @@
// Ray against sphere intersection test, fully pipelined.
//
// Input channel: a ray (origin, direction) and a sphere (radius, centre, id)
// are presented on the input ports and a transfer takes place at each rising
// clock edge where start is high and busy is low. Busy is never raised, so a
// new test may be started in every cycle.
// Output channel: done is high for exactly one cycle per test, in the order
// the tests were started, with the result on the output ports. A miss shows
// is_hit low and every other result field zero. The receiver cannot stall.
// The pipeline has 5 stages forming the discriminant, 32 square root stages
// (one root bit each), 4 stages choosing the distance and forming the hit
// point, 49 divider stages (one quotient bit each) for the normal and the
// output register. Throughput is one test per cycle.
// Configuration: min_distance is written whenever min_distance_we is high and
// must only change while no test is in flight. Reset sets it to 7 and empties
// the pipeline; no result appears until a test has been started.
module ray_sphere_intersect (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic min_distance_we,
	input logic [rsi_pkg::MDW-1:0] min_distance,
	input rsi_pkg::fx_t origin_x,
	input rsi_pkg::fx_t origin_y,
	input rsi_pkg::fx_t origin_z,
	input rsi_pkg::fx_t dir_x,
	input rsi_pkg::fx_t dir_y,
	input rsi_pkg::fx_t dir_z,
	input logic [rsi_pkg::RW-1:0] sphere_radius,
	input rsi_pkg::fx_t sphere_x,
	input rsi_pkg::fx_t sphere_y,
	input rsi_pkg::fx_t sphere_z,
	input logic [rsi_pkg::IDW-1:0] sphere_id,
	output logic done,
	output logic is_hit,
	output logic [rsi_pkg::RW-1:0] distance,
	output rsi_pkg::fx_t hit_x,
	output rsi_pkg::fx_t hit_y,
	output rsi_pkg::fx_t hit_z,
	output rsi_pkg::fx_t normal_x,
	output rsi_pkg::fx_t normal_y,
	output rsi_pkg::fx_t normal_z,
	output logic [rsi_pkg::IDW-1:0] hit_id
);
	import rsi_pkg::*;

	logic [MDW-1:0] min_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= MIN_DIST_RST;
		end else if (min_distance_we) begin
			min_dist_q <= min_distance;
		end
	end

	// The pipeline never holds off a transfer.
	assign busy = 1'b0;

	// Front end: centre offset, dot product, discriminant.
	logic fr_vld;
	logic [RAD_W-1:0] fr_rad;
	logic fr_neg;
	sq_side_t fr_side;

	rsi_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(start),
		.org({origin_z, origin_y, origin_x}),
		.dir({dir_z, dir_y, dir_x}),
		.cen({sphere_z, sphere_y, sphere_x}),
		.r(sphere_radius),
		.id(sphere_id),
		.out_vld(fr_vld),
		.rad(fr_rad),
		.neg(fr_neg),
		.side(fr_side)
	);

	logic sq_vld;
	logic [SQ_STAGES-1:0] sq_root;
	logic sq_neg;
	sq_side_t sq_side;

	rsi_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(fr_vld),
		.rad(fr_rad),
		.in_neg(fr_neg),
		.in_side(fr_side),
		.out_vld(sq_vld),
		.root(sq_root),
		.out_neg(sq_neg),
		.out_side(sq_side)
	);

	// Stage p1: choose the nearer root above the minimum distance, else the
	// farther one, and clamp the distance to the 31-bit range.
	logic signed [W+1:0] t1_c, t2_c, ts_c, md_c;
	logic hit_c;
	logic [RW-1:0] dist_c;

	always_comb begin
		md_c = $signed({{(W+2-MDW){1'b0}}, min_dist_q});
		t1_c = $signed({{2{sq_side.b[W-1]}}, sq_side.b}) - $signed({2'b00, sq_root});
		t2_c = $signed({{2{sq_side.b[W-1]}}, sq_side.b}) + $signed({2'b00, sq_root});
		ts_c = (t1_c > md_c) ? t1_c : t2_c;
		hit_c = !sq_neg && ((t1_c > md_c) || (t2_c > md_c));
		if (ts_c > $signed({3'b000, {RW{1'b1}}})) begin
			dist_c = {RW{1'b1}};
		end else begin
			dist_c = ts_c[RW-1:0];
		end
	end

	logic vld_p1, vld_p2, vld_p3, vld_p4;
	logic hit_p1, hit_p2, hit_p3;
	logic [RW-1:0] dist_p1, dist_p2, dist_p3;
	sq_side_t side_p1, side_p2, side_p3;
	logic signed [PROD_W-1:0] mh_p2 [3];
	fx_t pos_p3 [3];
	logic [DVD_W-1:0] dvd_p4 [3];
	logic [RW-1:0] r_p4;
	nrm_side_t ns_p4;

	// Stage p2 multiplies, p3 adds the origin, p4 forms the divider operands.
	logic signed [PROD_W-1:0] mh_c [3];
	fx_t pos_c [3];
	logic [DVD_W-1:0] dvd_c [3];
	logic [2:0] sgn_c;
	nrm_side_t ns_c;

	always_comb begin
		logic signed [63:0] p;
		logic signed [63:0] a;
		logic signed [DIFF_W-1:0] d;
		logic [DIFF_W-1:0] mag;
		for (int i = 0; i < 3; i++) begin
			p = $signed({{(64-RW){1'b0}}, dist_p1}) * sext($signed(side_p1.dir[i]));
			mh_c[i] = p[63:FRAC];
			a = 64'(mh_p2[i]);
			pos_c[i] = sat32(a + sext($signed(side_p2.org[i])));
			d = $signed({pos_p3[i][W-1], pos_p3[i]})
				- $signed({side_p3.cen[i][W-1], side_p3.cen[i]});
			sgn_c[i] = d[DIFF_W-1];
			mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
			dvd_c[i] = {mag, {FRAC{1'b0}}};
		end
		ns_c.hit = hit_p3;
		ns_c.len = dist_p3;
		ns_c.pos = {pos_p3[2], pos_p3[1], pos_p3[0]};
		ns_c.sgn = sgn_c;
		ns_c.rz = (side_p3.r == '0);
		ns_c.id = side_p3.id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
			vld_p4 <= 1'b0;
		end else begin
			vld_p1 <= sq_vld;
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
			vld_p4 <= vld_p3;
		end
	end

	always_ff @(posedge clk) begin
		hit_p1 <= hit_c;
		dist_p1 <= dist_c;
		side_p1 <= sq_side;

		hit_p2 <= hit_p1;
		dist_p2 <= dist_p1;
		side_p2 <= side_p1;
		mh_p2 <= mh_c;

		hit_p3 <= hit_p2;
		dist_p3 <= dist_p2;
		side_p3 <= side_p2;
		pos_p3 <= pos_c;

		dvd_p4 <= dvd_c;
		r_p4 <= side_p3.r;
		ns_p4 <= ns_c;
	end

	// Normal = (hit - centre) / radius, one divider per axis.
	logic [DVD_W-1:0] quo [3];

	for (genvar g = 0; g < 3; g++) begin : g_div
		rsi_div u_div (
			.clk(clk),
			.dvd(dvd_p4[g]),
			.dvs(r_p4),
			.quo(quo[g])
		);
	end

	// Everything else waits alongside the dividers.
	logic [DIV_STAGES-1:0] dl_vld_s;
	nrm_side_t dl_s [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_vld_s <= '0;
		end else begin
			dl_vld_s <= {dl_vld_s[DIV_STAGES-2:0], vld_p4};
		end
	end

	always_ff @(posedge clk) begin
		dl_s[0] <= ns_p4;
		for (int k = 1; k < DIV_STAGES; k++) begin
			dl_s[k] <= dl_s[k-1];
		end
	end

	nrm_side_t dl_out;
	fx_t nrm_c [3];

	assign dl_out = dl_s[DIV_STAGES-1];

	// Apply the sign to the quotient magnitude and saturate; a zero radius
	// gives a zero normal.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dl_out.rz) begin
				nrm_c[i] = '0;
			end else if (dl_out.sgn[i]) begin
				if (quo[i] > DVD_W'(33'h0_8000_0000)) begin
					nrm_c[i] = 32'sh8000_0000;
				end else begin
					nrm_c[i] = -$signed(quo[i][W-1:0]);
				end
			end else if (quo[i] > DVD_W'(33'h0_7FFF_FFFF)) begin
				nrm_c[i] = 32'sh7FFF_FFFF;
			end else begin
				nrm_c[i] = quo[i][W-1:0];
			end
		end
	end

	logic done_q, is_hit_q;
	logic [RW-1:0] distance_q;
	fx_t hit_q [3];
	fx_t nrm_q [3];
	logic [IDW-1:0] hit_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dl_vld_s[DIV_STAGES-1];
		end
	end

	// A miss clears every result field.
	always_ff @(posedge clk) begin
		is_hit_q <= dl_out.hit;
		distance_q <= dl_out.hit ? dl_out.len : '0;
		hit_id_q <= dl_out.hit ? dl_out.id : '0;
		for (int i = 0; i < 3; i++) begin
			hit_q[i] <= dl_out.hit ? $signed(dl_out.pos[i]) : '0;
			nrm_q[i] <= dl_out.hit ? nrm_c[i] : '0;
		end
	end

	assign done = done_q;
	assign is_hit = is_hit_q;
	assign distance = distance_q;
	assign hit_x = hit_q[0];
	assign hit_y = hit_q[1];
	assign hit_z = hit_q[2];
	assign normal_x = nrm_q[0];
	assign normal_y = nrm_q[1];
	assign normal_z = nrm_q[2];
	assign hit_id = hit_id_q;

endmodule

@@ sv/rsi_front.sv @@
module rsi_front (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input rsi_pkg::fx_t [2:0] org,
	input rsi_pkg::fx_t [2:0] dir,
	input rsi_pkg::fx_t [2:0] cen,
	input logic [rsi_pkg::RW-1:0] r,
	input logic [rsi_pkg::IDW-1:0] id,
	output logic out_vld,
	output logic [rsi_pkg::RAD_W-1:0] rad,
	output logic neg,
	output rsi_pkg::sq_side_t side
);
	import rsi_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	fx_t op_s1 [3];
	sq_side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic signed [PROD_W-1:0] po_s2 [3];
	logic [PROD_W-1:0] oo_s2 [3];
	logic [PROD_W-1:0] rr_s2;
	logic signed [SUM_W-1:0] sq_s3, sq_s4;
	logic [PROD_W-1:0] bb_s4;
	logic [RAD_W-1:0] rad_s5;
	logic neg_s5;

	fx_t op_c [3];
	logic signed [PROD_W-1:0] po_c [3];
	logic [PROD_W-1:0] oo_c [3];
	logic [PROD_W-1:0] rr_c;
	fx_t b_c;
	logic signed [63:0] sq_c;
	logic [PROD_W-1:0] bb_c;
	logic signed [63:0] det_c;
	logic signed [63:0] cl_c;
	sq_side_t side_c0, side_c2;

	always_comb begin
		logic signed [63:0] p;
		logic signed [63:0] q;
		logic [63:0] rp;
		logic signed [63:0] acc;
		logic signed [63:0] oacc;
		logic signed [63:0] a;
		for (int i = 0; i < 3; i++) begin
			op_c[i] = sat32(sext($signed(cen[i])) - sext($signed(org[i])));
			p = sext(op_s1[i]) * sext($signed(side_s1.dir[i]));
			q = sext(op_s1[i]) * sext(op_s1[i]);
			po_c[i] = p[63:FRAC];
			oo_c[i] = q[63:FRAC];
		end
		rp = {{(64-RW){1'b0}}, side_s1.r} * {{(64-RW){1'b0}}, side_s1.r};
		rr_c = rp[63:FRAC];

		side_c0.b = '0;
		side_c0.org = org;
		side_c0.dir = dir;
		side_c0.cen = cen;
		side_c0.r = r;
		side_c0.id = id;

		acc = '0;
		oacc = '0;
		for (int i = 0; i < 3; i++) begin
			a = 64'(po_s2[i]);
			acc = acc + a;
			oacc = oacc + $signed({{(64-PROD_W){1'b0}}, oo_s2[i]});
		end
		b_c = sat32(acc);
		sq_c = $signed({{(64-PROD_W){1'b0}}, rr_s2}) - oacc;

		side_c2 = side_s2;
		side_c2.b = b_c;

		p = sext(side_s3.b) * sext(side_s3.b);
		bb_c = p[63:FRAC];

		det_c = $signed({{(64-PROD_W){1'b0}}, bb_s4});
		a = 64'(sq_s4);
		det_c = det_c + a;
		cl_c = (det_c > DET_LIM) ? DET_LIM : det_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op_c;
		side_s1 <= side_c0;

		po_s2 <= po_c;
		oo_s2 <= oo_c;
		rr_s2 <= rr_c;
		side_s2 <= side_s1;

		sq_s3 <= sq_c[SUM_W-1:0];
		side_s3 <= side_c2;

		bb_s4 <= bb_c;
		sq_s4 <= sq_s3;
		side_s4 <= side_s3;

		neg_s5 <= det_c[63];
		rad_s5 <= 64'(cl_c) << FRAC;
		side_s5 <= side_s4;
	end

	assign out_vld = vld_s5;
	assign rad = rad_s5;
	assign neg = neg_s5;
	assign side = side_s5;

endmodule

@@ sv/rsi_sqrt.sv @@
module rsi_sqrt (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input logic [rsi_pkg::RAD_W-1:0] rad,
	input logic in_neg,
	input rsi_pkg::sq_side_t in_side,
	output logic out_vld,
	output logic [rsi_pkg::SQ_STAGES-1:0] root,
	output logic out_neg,
	output rsi_pkg::sq_side_t out_side
);
	import rsi_pkg::*;

	// One root bit per stage, most significant first.
	logic [SQ_STAGES-1:0] vld_s;
	sq_step_t st_s [SQ_STAGES];
	logic [RAD_W-1:0] x_s [SQ_STAGES];
	logic neg_s [SQ_STAGES];
	sq_side_t side_s [SQ_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SQ_STAGES-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		st_s[0] <= sq_step('0, '0, rad[RAD_W-1 -: 2]);
		x_s[0] <= rad << 2;
		neg_s[0] <= in_neg;
		side_s[0] <= in_side;
		for (int k = 1; k < SQ_STAGES; k++) begin
			st_s[k] <= sq_step(st_s[k-1].rem, st_s[k-1].root, x_s[k-1][RAD_W-1 -: 2]);
			x_s[k] <= x_s[k-1] << 2;
			neg_s[k] <= neg_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_vld = vld_s[SQ_STAGES-1];
	assign root = st_s[SQ_STAGES-1].root;
	assign out_neg = neg_s[SQ_STAGES-1];
	assign out_side = side_s[SQ_STAGES-1];

endmodule

@@ sv/rsi_div.sv @@
module rsi_div (
	input logic clk,
	input logic [rsi_pkg::DVD_W-1:0] dvd,
	input logic [rsi_pkg::RW-1:0] dvs,
	output logic [rsi_pkg::DVD_W-1:0] quo
);
	import rsi_pkg::*;

	// Restoring divider, one quotient bit per stage.
	logic [DIV_REM_W-1:0] rem_s [DIV_STAGES];
	logic [DVD_W-1:0] q_s [DIV_STAGES];
	logic [DVD_W-1:0] dvd_s [DIV_STAGES];
	logic [RW-1:0] dvs_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		div_step_t st;
		st = div_step('0, dvd[DVD_W-1], dvs);
		rem_s[0] <= st.rem;
		q_s[0] <= {{(DVD_W-1){1'b0}}, st.q};
		dvd_s[0] <= dvd << 1;
		dvs_s[0] <= dvs;
		for (int k = 1; k < DIV_STAGES; k++) begin
			st = div_step(rem_s[k-1], dvd_s[k-1][DVD_W-1], dvs_s[k-1]);
			rem_s[k] <= st.rem;
			q_s[k] <= {q_s[k-1][DVD_W-2:0], st.q};
			dvd_s[k] <= dvd_s[k-1] << 1;
			dvs_s[k] <= dvs_s[k-1];
		end
	end

	assign quo = q_s[DIV_STAGES-1];

endmodule

@@ sv/rsi_check.sv @@
module rsi_check (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [rsi_pkg::MDW-1:0] min_distance,
	input logic done,
	input logic is_hit,
	input logic [rsi_pkg::RW-1:0] distance,
	input rsi_pkg::fx_t hit_x,
	input rsi_pkg::fx_t hit_y,
	input rsi_pkg::fx_t hit_z,
	input rsi_pkg::fx_t normal_x,
	input rsi_pkg::fx_t normal_y,
	input rsi_pkg::fx_t normal_z,
	input logic [rsi_pkg::IDW-1:0] hit_id
);
	import rsi_pkg::*;

	// Every result comes from a start transfer the full pipeline latency earlier.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching start transfer");

	// A miss carries an all-zero result.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !is_hit |-> distance == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0
			&& normal_x == '0 && normal_y == '0 && normal_z == '0 && hit_id == '0)
		else $error("miss with non-zero result fields");

	// A hit lies beyond the minimum distance.
	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_hit |-> distance > {{(RW-MDW){1'b0}}, min_distance})
		else $error("hit at or below the minimum distance");

endmodule

bind ray_sphere_intersect rsi_check u_rsi_check (.*);
